// ===== hdl/vtb_pkg.sv =====
// Shared types, constants and helper functions for the vertex transform block.
`default_nettype none
package vtb_pkg;

    localparam int NUM_COEF         = 6;
    localparam int PADDR_W          = 6;
    localparam int MAX_VERTICES_DEF = 65536;
    localparam int DIV_NUM_W        = 48;
    localparam int DIV_DEN_W        = 32;
    localparam int SQRT_STEPS       = 32;

    localparam logic [63:0] COEF_RST_DIAG = 64'h0001_0000_0000_0000;
    localparam logic [63:0] NRM_EPS_SQ    = 64'd1152921;

    typedef logic [NUM_COEF-1:0][63:0] coef_bank_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic               has_normal;
        logic [63:0]        tex_uv;
        logic               last;
    } vtx_in_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [15:0] out_nrm_x;
        logic signed [15:0] out_nrm_y;
        logic signed [15:0] out_nrm_z;
        logic [63:0]        out_uv;
        logic               is_last;
        logic signed [31:0] min_height;
        logic signed [31:0] max_height;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_z;
    } vtx_out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PMUL,
        OP_PACC,
        OP_NMUL,
        OP_NACC,
        OP_MAX,
        OP_SHR,
        OP_SHL,
        OP_SQMUL,
        OP_SQACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_NDIV_GO,
        OP_NDIV_TAKE,
        OP_TINY,
        OP_STATS,
        OP_MDIV_GO,
        OP_MDIV_TAKE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] row;
        logic [1:0] col;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic big;
        logic mx_hi;
        logic mx_below;
        logic div_busy;
        logic div_done;
        logic out_free;
    } status_t;

    // column-major matrix entry from the packed register bank
    function automatic logic signed [31:0] mat_entry(coef_bank_t b, logic [3:0] idx);
        logic signed [31:0] v;
        v = '0;
        case (idx)
            4'd0:    v = b[0][63:32];
            4'd1:    v = b[0][31:0];
            4'd2:    v = b[1][63:32];
            4'd4:    v = b[1][31:0];
            4'd5:    v = b[2][63:32];
            4'd6:    v = b[2][31:0];
            4'd8:    v = b[3][63:32];
            4'd9:    v = b[3][31:0];
            4'd10:   v = b[4][63:32];
            4'd12:   v = b[4][31:0];
            4'd13:   v = b[5][63:32];
            4'd14:   v = b[5][31:0];
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [49:0] mag50(logic signed [49:0] x);
        return x[49] ? 50'(-x) : 50'(x);
    endfunction

    function automatic logic [47:0] mag48(logic signed [47:0] x);
        return x[47] ? 48'(-x) : 48'(x);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/vtb_regs.sv =====
// APB-style register bank holding the six matrix coefficient pairs.
`default_nettype none
module vtb_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vtb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [63:0]                   pwdata,
    output logic      [63:0]                   prdata,
    output logic                               pready,
    output vtb_pkg::coef_bank_t                coef
);
    import vtb_pkg::*;

    coef_bank_t coef_reg;
    logic [2:0] idx;

    assign idx    = paddr[5:3];
    assign pready = 1'b1;
    assign coef   = coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                coef_reg[i] <= (i % 2 == 0) ? COEF_RST_DIAG : 64'd0;
            end
        end else if (psel && penable && pwrite && (idx < 3'(NUM_COEF))) begin
            coef_reg[idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (idx < 3'(NUM_COEF)) begin
            prdata = coef_reg[idx];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/vtb_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module vtb_divider (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [vtb_pkg::DIV_NUM_W-1:0]   num,
    input  wire logic [vtb_pkg::DIV_DEN_W-1:0]   den,
    output logic                                 busy,
    output logic                                 done,
    output logic      [vtb_pkg::DIV_NUM_W-1:0]   quot
);
    import vtb_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;

    assign trial = {rem_reg[DIV_DEN_W-1:0], q_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(DIV_NUM_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= diff;
                q_reg   <= {q_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                q_reg   <= {q_reg[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

// ===== hdl/vtb_ctrl.sv =====
// Sequencer that steps the datapath through one vertex.
`default_nettype none
module vtb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire vtb_pkg::status_t  status,
    output vtb_pkg::cmd_t          cmd
);
    import vtb_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE      = 21'h000001,
        S_PMUL      = 21'h000002,
        S_PACC      = 21'h000004,
        S_NMUL      = 21'h000008,
        S_NACC      = 21'h000010,
        S_MAX       = 21'h000020,
        S_CLS       = 21'h000040,
        S_SHR       = 21'h000080,
        S_SQMUL     = 21'h000100,
        S_SQACC     = 21'h000200,
        S_CHK       = 21'h000400,
        S_SHL       = 21'h000800,
        S_SQRT_INIT = 21'h001000,
        S_SQRT      = 21'h002000,
        S_NDIV_GO   = 21'h004000,
        S_NDIV_WAIT = 21'h008000,
        S_TINY      = 21'h010000,
        S_STATS     = 21'h020000,
        S_MDIV_GO   = 21'h040000,
        S_MDIV_WAIT = 21'h080000,
        S_EMIT      = 21'h100000
    } state_t;

    localparam int CNT_W = $clog2(SQRT_STEPS);

    state_t           state_reg, state_next;
    logic [1:0]       row_reg, row_next, col_reg, col_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             scaled_reg, scaled_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            cnt_reg    <= '0;
            scaled_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            cnt_reg    <= cnt_next;
            scaled_reg <= scaled_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        cnt_next    = cnt_reg;
        scaled_next = scaled_reg;
        cmd.op      = OP_NONE;
        cmd.row     = row_reg;
        cmd.col     = col_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = S_PMUL;
                end
            end
            S_PMUL: begin
                cmd.op     = OP_PMUL;
                state_next = S_PACC;
            end
            S_PACC: begin
                cmd.op     = OP_PACC;
                state_next = S_PMUL;
                if (col_reg == 2'd2) begin
                    col_next = '0;
                    if (row_reg == 2'd2) begin
                        row_next   = '0;
                        state_next = S_NMUL;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_NMUL: begin
                cmd.op     = OP_NMUL;
                state_next = S_NACC;
            end
            S_NACC: begin
                cmd.op     = OP_NACC;
                state_next = S_NMUL;
                if (col_reg == 2'd2) begin
                    col_next = '0;
                    if (row_reg == 2'd2) begin
                        row_next   = '0;
                        state_next = S_MAX;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_MAX: begin
                cmd.op     = OP_MAX;
                state_next = S_CLS;
            end
            S_CLS: begin
                if (status.mx_hi) begin
                    state_next = S_SHR;
                end else begin
                    scaled_next = 1'b0;
                    state_next  = S_SQMUL;
                end
            end
            S_SHR: begin
                if (status.mx_hi) begin
                    cmd.op = OP_SHR;
                end else begin
                    scaled_next = 1'b1;
                    state_next  = S_SQMUL;
                end
            end
            S_SQMUL: begin
                cmd.op     = OP_SQMUL;
                state_next = S_SQACC;
            end
            S_SQACC: begin
                cmd.op = OP_SQACC;
                if (col_reg == 2'd2) begin
                    col_next   = '0;
                    state_next = scaled_reg ? S_SQRT_INIT : S_CHK;
                end else begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_SQMUL;
                end
            end
            S_CHK: begin
                state_next = status.big ? S_SHL : S_TINY;
            end
            S_SHL: begin
                if (status.mx_below) begin
                    cmd.op = OP_SHL;
                end else begin
                    scaled_next = 1'b1;
                    state_next  = S_SQMUL;
                end
            end
            S_SQRT_INIT: begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    col_next   = '0;
                    state_next = S_NDIV_GO;
                end
            end
            S_NDIV_GO: begin
                cmd.op     = OP_NDIV_GO;
                state_next = S_NDIV_WAIT;
            end
            S_NDIV_WAIT: begin
                if (status.div_done) begin
                    cmd.op = OP_NDIV_TAKE;
                    if (col_reg == 2'd2) begin
                        col_next   = '0;
                        state_next = S_STATS;
                    end else begin
                        col_next   = col_reg + 1'b1;
                        state_next = S_NDIV_GO;
                    end
                end
            end
            S_TINY: begin
                cmd.op     = OP_TINY;
                state_next = S_STATS;
            end
            S_STATS: begin
                cmd.op   = OP_STATS;
                col_next = '0;
                state_next = status.last ? S_MDIV_GO : S_EMIT;
            end
            S_MDIV_GO: begin
                cmd.op     = OP_MDIV_GO;
                state_next = S_MDIV_WAIT;
            end
            S_MDIV_WAIT: begin
                if (status.div_done) begin
                    cmd.op = OP_MDIV_TAKE;
                    if (col_reg == 2'd1) begin
                        col_next   = '0;
                        state_next = S_EMIT;
                    end else begin
                        col_next   = col_reg + 1'b1;
                        state_next = S_MDIV_GO;
                    end
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !status.div_busy)
        else $error("divider busy while sequencer idle");
    a_mean_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MDIV_GO) |-> status.last)
        else $error("mean division on a vertex that is not last");
    a_done_awaited: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == S_NDIV_WAIT || state_reg == S_MDIV_WAIT))
        else $error("divider result arrived with nobody waiting");
`endif

endmodule
`default_nettype wire

// ===== hdl/vtb_datapath.sv =====
// Datapath: shared multiplier, accumulators, root and divide units, mesh statistics.
`default_nettype none
module vtb_datapath #(
    parameter int MAX_VERTICES = vtb_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire vtb_pkg::coef_bank_t coef,
    input  wire vtb_pkg::vtx_in_t    s_data,
    input  wire vtb_pkg::cmd_t       cmd,
    output vtb_pkg::status_t         status,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vtb_pkg::vtx_out_t        m_data
);
    import vtb_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    vtx_in_t                   in_reg;
    logic signed [63:0]        prod_reg;
    logic signed [67:0]        acc_reg;
    logic signed [31:0]        wp_reg [3];
    logic signed [49:0]        r_reg  [3];
    logic [49:0]               mx_reg;
    logic [63:0]               l2_reg;
    logic [63:0]               sq_v_reg, sq_root_reg, sq_bit_reg;
    logic signed [15:0]        on_reg [3];
    logic signed [31:0]        mean_reg [2];
    logic signed [31:0]        min_y_reg, max_y_reg;
    logic signed [47:0]        sum_x_reg, sum_z_reg;
    logic [CNT_W-1:0]          count_reg;
    vtx_out_t                  out_reg;
    logic                      m_valid_reg;

    logic [3:0]                mi;
    logic signed [31:0]        m_coef, t_coef, mul_a, mul_b, p_sel;
    logic signed [15:0]        n_sel;
    logic signed [67:0]        p_nxt, p_shv;
    logic [49:0]               r_mag [3];
    logic [63:0]               sq_try;
    logic [31:0]               len;
    logic [DIV_NUM_W-1:0]      div_num, div_quot;
    logic [DIV_DEN_W-1:0]      div_den;
    logic                      div_start, div_busy, div_done;
    logic signed [47:0]        sum_sel;
    logic [47:0]               sum_mag;

    assign mi     = {cmd.col, cmd.row};
    assign m_coef = mat_entry(coef, mi);
    assign t_coef = mat_entry(coef, 4'd12 + {2'b00, cmd.row});

    always_comb begin
        case (cmd.col)
            2'd0:    p_sel = in_reg.pos_x;
            2'd1:    p_sel = in_reg.pos_y;
            default: p_sel = in_reg.pos_z;
        endcase
        if (in_reg.has_normal) begin
            case (cmd.col)
                2'd0:    n_sel = in_reg.nrm_x;
                2'd1:    n_sel = in_reg.nrm_y;
                default: n_sel = in_reg.nrm_z;
            endcase
        end else begin
            n_sel = (cmd.col == 2'd1) ? 16'sd16384 : 16'sd0;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_mag[k] = mag50(r_reg[k]);
        end
    end

    always_comb begin
        mul_a = m_coef;
        mul_b = p_sel;
        if (cmd.op == OP_NMUL) begin
            mul_b = 32'(n_sel);
        end else if (cmd.op == OP_SQMUL) begin
            mul_a = $signed(r_mag[cmd.col][31:0]);
            mul_b = $signed(r_mag[cmd.col][31:0]);
        end
    end

    // position: t*2^16 + half LSB + sum of products, then floor to Q16.16
    always_comb begin
        if (cmd.col == 2'd0) begin
            p_nxt = ((68'(t_coef)) <<< 16) + 68'sd32768 + 68'(prod_reg);
        end else begin
            p_nxt = acc_reg + 68'(prod_reg);
        end
        p_shv = p_nxt >>> 16;
    end

    assign sq_try = sq_root_reg + sq_bit_reg;
    assign len    = (sq_root_reg[31:0] == 32'd0) ? 32'd1 : sq_root_reg[31:0];

    assign sum_sel = (cmd.col == 2'd0) ? sum_x_reg : sum_z_reg;
    assign sum_mag = mag48(sum_sel);

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (cmd.op == OP_NDIV_GO) begin
            div_start = 1'b1;
            div_num   = (48'(r_mag[cmd.col][30:0]) << 14) + 48'(len >> 1);
            div_den   = len;
        end else if (cmd.op == OP_MDIV_GO) begin
            div_start = 1'b1;
            div_num   = sum_mag + 48'(count_reg >> 1);
            div_den   = DIV_DEN_W'(count_reg);
        end
    end

    vtb_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                in_reg <= s_data;
            end
            OP_PMUL, OP_NMUL, OP_SQMUL: begin
                prod_reg <= mul_a * mul_b;
            end
            OP_PACC: begin
                acc_reg <= p_nxt;
                if (cmd.col == 2'd2) begin
                    if (p_shv > 68'sh7FFFFFFF) begin
                        wp_reg[cmd.row] <= 32'sh7FFFFFFF;
                    end else if (p_shv < 68'shFFFFFFFFF80000000) begin
                        wp_reg[cmd.row] <= 32'sh80000000;
                    end else begin
                        wp_reg[cmd.row] <= p_shv[31:0];
                    end
                end
            end
            OP_NACC: begin
                if (cmd.col == 2'd0) begin
                    r_reg[cmd.row] <= prod_reg[49:0];
                end else begin
                    r_reg[cmd.row] <= r_reg[cmd.row] + prod_reg[49:0];
                end
            end
            OP_MAX: begin
                if (r_mag[0] >= r_mag[1] && r_mag[0] >= r_mag[2]) begin
                    mx_reg <= r_mag[0];
                end else if (r_mag[1] >= r_mag[2]) begin
                    mx_reg <= r_mag[1];
                end else begin
                    mx_reg <= r_mag[2];
                end
            end
            OP_SHR: begin
                mx_reg <= mx_reg >> 1;
                for (int k = 0; k < 3; k++) begin
                    r_reg[k] <= r_reg[k] >>> 1;
                end
            end
            OP_SHL: begin
                mx_reg <= mx_reg << 1;
                for (int k = 0; k < 3; k++) begin
                    r_reg[k] <= r_reg[k] <<< 1;
                end
            end
            OP_SQACC: begin
                if (cmd.col == 2'd0) begin
                    l2_reg <= prod_reg;
                end else begin
                    l2_reg <= l2_reg + prod_reg;
                end
            end
            OP_SQRT_INIT: begin
                sq_v_reg    <= l2_reg;
                sq_root_reg <= '0;
                sq_bit_reg  <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP: begin
                if (sq_v_reg >= sq_try) begin
                    sq_v_reg    <= sq_v_reg - sq_try;
                    sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_root_reg <= sq_root_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_NDIV_TAKE: begin
                if (r_reg[cmd.col][49]) begin
                    on_reg[cmd.col] <= (div_quot > 48'd32768) ? 16'sh8000 :
                                       16'(-div_quot[15:0]);
                end else begin
                    on_reg[cmd.col] <= (div_quot > 48'd32767) ? 16'sh7FFF :
                                       div_quot[15:0];
                end
            end
            OP_TINY: begin
                for (int k = 0; k < 3; k++) begin
                    logic signed [49:0] tv;
                    tv = (r_reg[k] + 50'sh8000) >>> 16;
                    if (tv > 50'sh7FFF) begin
                        on_reg[k] <= 16'sh7FFF;
                    end else if (tv < 50'sh3FFFFFFFF8000) begin
                        on_reg[k] <= 16'sh8000;
                    end else begin
                        on_reg[k] <= tv[15:0];
                    end
                end
            end
            OP_MDIV_TAKE: begin
                if (sum_sel[47]) begin
                    mean_reg[cmd.col[0]] <= (div_quot > 48'h8000_0000) ? 32'sh80000000 :
                                            32'(-div_quot[31:0]);
                end else begin
                    mean_reg[cmd.col[0]] <= (div_quot > 48'h7FFF_FFFF) ? 32'sh7FFFFFFF :
                                            div_quot[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    // running mesh statistics
    always_ff @(posedge aclk) begin
        logic signed [48:0] sx49, sz49;
        sx49 = 49'(sum_x_reg) + 49'(wp_reg[0]);
        sz49 = 49'(sum_z_reg) + 49'(wp_reg[2]);
        if (!aresetn) begin
            min_y_reg <= 32'sh7FFFFFFF;
            max_y_reg <= 32'sh80000000;
            sum_x_reg <= '0;
            sum_z_reg <= '0;
            count_reg <= '0;
        end else if (cmd.op == OP_STATS) begin
            if (wp_reg[1] < min_y_reg) begin
                min_y_reg <= wp_reg[1];
            end
            if (wp_reg[1] > max_y_reg) begin
                max_y_reg <= wp_reg[1];
            end
            if (sx49[48] != sx49[47]) begin
                sum_x_reg <= sx49[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
            end else begin
                sum_x_reg <= sx49[47:0];
            end
            if (sz49[48] != sz49[47]) begin
                sum_z_reg <= sz49[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
            end else begin
                sum_z_reg <= sz49[47:0];
            end
            if (count_reg < CNT_W'(MAX_VERTICES)) begin
                count_reg <= count_reg + 1'b1;
            end
        end else if (cmd.op == OP_EMIT && in_reg.last) begin
            min_y_reg <= 32'sh7FFFFFFF;
            max_y_reg <= 32'sh80000000;
            sum_x_reg <= '0;
            sum_z_reg <= '0;
            count_reg <= '0;
        end
    end

    // output register, frees the sequencer while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            out_reg.out_pos_x  <= wp_reg[0];
            out_reg.out_pos_y  <= wp_reg[1];
            out_reg.out_pos_z  <= wp_reg[2];
            out_reg.out_nrm_x  <= on_reg[0];
            out_reg.out_nrm_y  <= on_reg[1];
            out_reg.out_nrm_z  <= on_reg[2];
            out_reg.out_uv     <= in_reg.tex_uv;
            out_reg.is_last    <= in_reg.last;
            out_reg.min_height <= in_reg.last ? min_y_reg : 32'sd0;
            out_reg.max_height <= in_reg.last ? max_y_reg : 32'sd0;
            out_reg.mean_x     <= in_reg.last ? mean_reg[0] : 32'sd0;
            out_reg.mean_z     <= in_reg.last ? mean_reg[1] : 32'sd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign status.last     = in_reg.last;
    assign status.big      = (l2_reg > NRM_EPS_SQ);
    assign status.mx_hi    = |mx_reg[49:30];
    assign status.mx_below = ~|mx_reg[49:29];
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above its limit");
    a_extremes_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.is_last) |-> (out_reg.min_height <= out_reg.max_height))
        else $error("mesh minimum above maximum");
    a_stats_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.is_last) |->
        (out_reg.min_height == 0 && out_reg.max_height == 0 &&
         out_reg.mean_x == 0 && out_reg.mean_z == 0))
        else $error("statistics on a result that is not last");
`endif

endmodule
`default_nettype wire

// ===== hdl/vertex_transform_bounds.sv =====
// Top level: vertex transform with mesh bounds, register bank, sequencer and datapath.
// Usage:
//   s_valid/s_ready/s_data carry one vertex per transaction; m_valid/m_ready/m_data
//   carry one transformed vertex per transaction, in input order.
//   The matrix is written through the APB-style port (six 64-bit registers at
//   byte addresses 0, 8, ..., 40) while no vertex is in flight; pready is always high.
// Processing:
//   One vertex at a time. Position and rotation use one shared 32x32 multiplier,
//   18 products in all. A tiny normal skips the root and divides. A renormalized
//   normal adds the block-scaling shifts (one bit per cycle), more squaring products,
//   an integer square root and three divides (48 iterations each plus start and
//   handoff). The last vertex of a mesh adds two more divides for the means; the
//   next vertex can be accepted once the result is in the output register.
// Reset (aresetn low, synchronous): identity matrix, running statistics cleared,
//   no result pending. No clearing pass.
// Stall: a result waits in the output register while m_ready is low; the next
//   vertex may be processed meanwhile and waits before its result is loaded.
`default_nettype none
module vertex_transform_bounds #(
    parameter int MAX_VERTICES = vtb_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire vtb_pkg::vtx_in_t            s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output vtb_pkg::vtx_out_t                m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vtb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic      [63:0]                 prdata,
    output logic                             pready
);
    import vtb_pkg::*;

    coef_bank_t coef;
    cmd_t       cmd;
    status_t    status;

    vtb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    vtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vtb_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef    (coef),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
